// ===== src/slab_block_allocator_top_assert.svh =====
// Assertion macros shared by the allocator checker.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef SLAB_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SLAB_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sba_checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sba_checker: next-cycle property failed");

`endif

// ===== src/sba_pkg.sv =====
`default_nettype none

package sba_pkg;

    // Fixed field widths of the request and result transfers.
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 13;
    localparam int MIN_BLOCK = 4;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // Request kinds carried on s_tuser.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_FOREIGN  = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== src/sba_ram.sv =====
`default_nettype none

// Simple dual-port synchronous RAM: one write port, one registered read port.
module sba_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/sba_rem_unit.sv =====
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, DIV_W dividend bits a pass.
// The remainder is valid in the cycle where done is high.
module sba_rem_unit
    import sba_pkg::*;
#(
    parameter int DIV_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [SIZE_W-1:0] divisor,
    output logic                   done,
    output logic      [SIZE_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   reduced;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            reduced = trial - {1'b0, dvs_reg};
        end else begin
            reduced = trial;
        end
    end

    // Sequencing of a pass.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = reduced[SIZE_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/slab_block_allocator_top.sv =====
// Slab block allocator, one request at a time.
// Allocate: the newest slab is probed first, then each older slab in turn (S_SCAN), plus an
// S_LINK step for a free-list link read; at most SLAB_COUNT slabs are probed before S_DONE.
// Free: S_FRD reads the slab entry, then S_FDIV waits for the bit-serial remainder unit.
// The next request is taken the cycle after a result enters the output register.
// Reset (aresetn low, synchronous) empties the slab table count; memories are not cleared.
`default_nettype none

module slab_block_allocator_top
    import sba_pkg::*;
#(
    parameter int SLAB_COUNT = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration: region_start.
    input  wire logic                 cfg_wr_en,
    input  wire logic [ADDR_W-1:0]    cfg_wr_data,
    // Requests.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // block_size[12:0], address[44:13], zero pad
    input  wire logic                 s_tuser,  // kind
    // Results.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // block_address[31:0], status[33:32], zero pad
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int OFF_W      = PAGE_SHIFT + 1;
    localparam int SLAB_W     = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLAB_COUNT + 1);
    localparam int LINK_AW    = SLAB_W + PAGE_SHIFT - 2;
    localparam int SUM_W      = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W) + 1;

    localparam logic [OFF_W-1:0] PAGE_OFF = OFF_W'(PAGE_BYTES);
    localparam logic [SUM_W-1:0] PAGE_SUM = SUM_W'(PAGE_BYTES);

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  bump;
        logic [OFF_W-1:0]  head;
    } slab_ent_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_LINK = 6'b000100,
        S_FRD  = 6'b001000,
        S_FDIV = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      region_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [SLAB_W-1:0]      idx_reg, idx_next;
    logic [PAGE_SHIFT-1:0]  off_reg, off_next;
    slab_ent_t              ent_reg, ent_next;
    status_t                status_reg, status_next;
    logic                   use_addr_reg, use_addr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic                   slab_wr_en;
    logic [SLAB_W-1:0]      slab_wr_addr;
    slab_ent_t              slab_wr_data;
    logic [SLAB_W-1:0]      slab_rd_addr;
    logic [$bits(slab_ent_t)-1:0] slab_rd_bits;
    slab_ent_t              slab_rd;
    logic                   link_wr_en;
    logic [LINK_AW-1:0]     link_wr_addr;
    logic [OFF_W-1:0]       link_wr_data;
    logic [LINK_AW-1:0]     link_rd_addr;
    logic [OFF_W-1:0]       link_rd_data;

    // Remainder unit.
    logic                   rem_start;
    logic                   rem_done;
    logic [SIZE_W-1:0]      rem_value;

    // Request fields and derived values.
    logic                   in_kind;
    logic [SIZE_W-1:0]      in_size;
    logic [ADDR_W-1:0]      in_addr;
    logic [ADDR_W-1:0]      free_diff;
    logic [ADDR_W-1:0]      free_slab;
    logic                   size_bad;
    logic                   ent_match;
    logic                   head_ok;
    logic [SUM_W-1:0]       bump_sum;
    logic                   bump_ok;
    logic [PAGE_SHIFT-1:0]  blk_start;
    logic [SUM_W-1:0]       blk_end;
    logic                   load_out;
    logic [ADDR_W-1:0]      out_addr;

    assign in_kind = s_tuser;
    assign in_size = s_tdata[SIZE_W-1:0];
    assign in_addr = s_tdata[SIZE_W +: ADDR_W];

    assign free_diff = in_addr - region_reg;
    assign free_slab = free_diff >> PAGE_SHIFT;
    assign size_bad  = (in_size < SIZE_W'(MIN_BLOCK)) || (ADDR_W'(in_size) > ADDR_W'(PAGE_BYTES));

    // Slab entry checks on the entry coming out of the table.
    assign slab_rd   = slab_ent_t'(slab_rd_bits);
    assign ent_match = (slab_rd.size == size_reg);
    assign head_ok   = (slab_rd.head < PAGE_OFF);
    assign bump_sum  = SUM_W'(slab_rd.bump) + SUM_W'(slab_rd.size);
    assign bump_ok   = (bump_sum <= PAGE_SUM);

    // Start of the block that holds a freed address, and the end of that block.
    assign blk_start = off_reg - PAGE_SHIFT'(rem_value);
    assign blk_end   = SUM_W'(blk_start) + SUM_W'(ent_reg.size);

    assign s_tready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign out_addr = use_addr_reg ? (region_reg + ADDR_W'({idx_reg, off_reg})) : '0;

    // Request sequencer.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        size_next     = size_reg;
        idx_next      = idx_reg;
        off_next      = off_reg;
        ent_next      = ent_reg;
        status_next   = status_reg;
        use_addr_next = use_addr_reg;
        slab_wr_en    = 1'b0;
        slab_wr_addr  = idx_reg;
        slab_wr_data  = ent_reg;
        slab_rd_addr  = idx_reg;
        link_wr_en    = 1'b0;
        link_wr_addr  = {idx_reg, blk_start[PAGE_SHIFT-1:2]};
        link_wr_data  = ent_reg.head;
        link_rd_addr  = {idx_reg, slab_rd.head[PAGE_SHIFT-1:2]};
        rem_start     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    status_next   = ST_OK;
                    use_addr_next = 1'b0;
                    size_next     = in_size;
                    if (in_kind == KIND_ALLOC) begin
                        if (size_bad) begin
                            status_next = ST_BAD_SIZE;
                            state_next  = S_DONE;
                        end else if (count_reg == '0) begin
                            // Empty table: open the first slab right away.
                            slab_wr_en    = 1'b1;
                            slab_wr_addr  = '0;
                            slab_wr_data  = '{size: in_size, bump: OFF_W'(in_size),
                                              head: PAGE_OFF};
                            count_next    = CNT_W'(1);
                            idx_next      = '0;
                            off_next      = '0;
                            use_addr_next = 1'b1;
                            state_next    = S_DONE;
                        end else begin
                            slab_rd_addr = SLAB_W'(count_reg - 1'b1);
                            idx_next     = SLAB_W'(count_reg - 1'b1);
                            state_next   = S_SCAN;
                        end
                    end else begin
                        if (in_addr == '0) begin
                            state_next = S_DONE;
                        end else if (free_slab >= ADDR_W'(count_reg)) begin
                            status_next = ST_FOREIGN;
                            state_next  = S_DONE;
                        end else begin
                            slab_rd_addr = free_slab[SLAB_W-1:0];
                            idx_next     = free_slab[SLAB_W-1:0];
                            off_next     = free_diff[PAGE_SHIFT-1:0];
                            state_next   = S_FRD;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Entry idx_reg is on the read port; prefetch the next older one.
                slab_rd_addr = idx_reg - 1'b1;
                if (ent_match && head_ok) begin
                    ent_next   = slab_rd;
                    off_next   = slab_rd.head[PAGE_SHIFT-1:0];
                    state_next = S_LINK;
                end else if (ent_match && bump_ok) begin
                    slab_wr_en    = 1'b1;
                    slab_wr_data  = '{size: slab_rd.size, bump: bump_sum[OFF_W-1:0],
                                      head: slab_rd.head};
                    off_next      = slab_rd.bump[PAGE_SHIFT-1:0];
                    use_addr_next = 1'b1;
                    state_next    = S_DONE;
                end else if (idx_reg == '0) begin
                    if (count_reg == CNT_W'(SLAB_COUNT)) begin
                        status_next = ST_FULL;
                    end else begin
                        // No slab can serve the size: open a new one.
                        slab_wr_en    = 1'b1;
                        slab_wr_addr  = SLAB_W'(count_reg);
                        slab_wr_data  = '{size: size_reg, bump: OFF_W'(size_reg),
                                          head: PAGE_OFF};
                        count_next    = count_reg + 1'b1;
                        idx_next      = SLAB_W'(count_reg);
                        off_next      = '0;
                        use_addr_next = 1'b1;
                    end
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end

            S_LINK: begin
                // Pop the freed block: its link becomes the new head.
                slab_wr_en    = 1'b1;
                slab_wr_data  = '{size: ent_reg.size, bump: ent_reg.bump, head: link_rd_data};
                use_addr_next = 1'b1;
                state_next    = S_DONE;
            end

            S_FRD: begin
                ent_next   = slab_rd;
                rem_start  = 1'b1;
                state_next = S_FDIV;
            end

            S_FDIV: begin
                if (rem_done) begin
                    if (blk_end <= PAGE_SUM) begin
                        // Push the block onto the slab's free list.
                        link_wr_en   = 1'b1;
                        slab_wr_en   = 1'b1;
                        slab_wr_data = '{size: ent_reg.size, bump: ent_reg.bump,
                                         head: OFF_W'(blk_start)};
                        status_next  = ST_OK;
                    end else begin
                        status_next = ST_FOREIGN;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({status_reg, out_addr});
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            region_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                region_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        size_reg     <= size_next;
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        ent_reg      <= ent_next;
        status_reg   <= status_next;
        use_addr_reg <= use_addr_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Slab descriptor table.
    sba_ram #(
        .DW ($bits(slab_ent_t)),
        .AW (SLAB_W)
    ) u_slab_ram (
        .aclk    (aclk),
        .wr_en   (slab_wr_en),
        .wr_addr (slab_wr_addr),
        .wr_data (slab_wr_data),
        .rd_addr (slab_rd_addr),
        .rd_data (slab_rd_bits)
    );

    // Free-list links, one per minimum-size block position.
    sba_ram #(
        .DW (OFF_W),
        .AW (LINK_AW)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    // Page offset modulo block size for frees.
    sba_rem_unit #(
        .DIV_W (PAGE_SHIFT)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (off_reg),
        .divisor   (slab_rd.size),
        .done      (rem_done),
        .remainder (rem_value)
    );

endmodule

`default_nettype wire

// ===== src/sba_checker.sv =====
`default_nettype none
`include "slab_block_allocator_top_assert.svh"

// Port-level checks for the allocator.
module sba_checker
    import sba_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A failed request never hands out an address.
    `SBA_ASSERT_IMPL(a_err_no_addr, m_tvalid && (m_tdata[33:32] != ST_OK), m_tdata[31:0] == '0)

    // Requests are processed one at a time.
    `SBA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // A new result only appears while the allocator was busy, with s_tready low, just before it.
    `SBA_ASSERT_IMPL(a_result_after_work, $rose(m_tvalid), !$past(s_tready))

    // A stalled result holds.
    `SBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind slab_block_allocator_top sba_checker u_sba_checker (.*);

`default_nettype wire

// ===== bench/slab_block_allocator_top_test.sv =====
`timescale 1ns / 100ps

module slab_block_allocator_top_test;
    import sba_pkg::*;

    localparam int SLABS        = 16;
    localparam int PAGE         = 4096;
    localparam int LINKS        = PAGE / MIN_BLOCK;
    localparam int IDLE_LIMIT   = 2000;
    localparam int END_WAIT     = 40;
    localparam int RANDOM_ITEMS = 200;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } result_t;

    // A block handed out and not yet returned, kept as an offset from region_start
    // so that it stays valid when the region moves.
    typedef struct {
        bit [31:0]   offset;
        int unsigned size;
    } live_block_t;

    // Slab table predictor and the queue of results it still waits for.
    class slab_ledger;
        bit [31:0]   region;
        int          open_slabs;
        int unsigned slab_size[SLABS];
        int unsigned bump_off[SLABS];
        int unsigned head_off[SLABS];
        int unsigned next_link[SLABS * LINKS];
        result_t     pending_results[$];
        int unsigned mismatches;

        function new();
            region     = '0;
            open_slabs = 0;
            mismatches = 0;
        endfunction

        // Works out the result of an accepted request and queues it.
        function result_t note_request(logic kind, logic [SIZE_W-1:0] size,
                                       logic [ADDR_W-1:0] addr);
            result_t     r;
            int          k;
            bit          found;
            int unsigned off;
            int unsigned sz;
            bit [31:0]   diff;
            bit [31:0]   slot;
            r.addr   = '0;
            r.status = ST_OK;
            found    = 1'b0;
            if (kind == KIND_ALLOC) begin
                if (size < MIN_BLOCK || size > PAGE) begin
                    r.status = ST_BAD_SIZE;
                end else begin
                    // Newest slab first; a freed block wins over a never-used one.
                    for (k = open_slabs - 1; k >= 0 && !found; k--) begin
                        if (slab_size[k] == size) begin
                            if (head_off[k] < PAGE) begin
                                off         = head_off[k];
                                head_off[k] = next_link[k * LINKS + off / MIN_BLOCK];
                                found       = 1'b1;
                            end else if (bump_off[k] + size <= PAGE) begin
                                off         = bump_off[k];
                                bump_off[k] = bump_off[k] + size;
                                found       = 1'b1;
                            end
                            if (found) begin
                                r.addr = region + 32'(k * PAGE + off);
                            end
                        end
                    end
                    if (!found) begin
                        if (open_slabs >= SLABS) begin
                            r.status = ST_FULL;
                        end else begin
                            k            = open_slabs;
                            slab_size[k] = size;
                            head_off[k]  = PAGE;
                            bump_off[k]  = size;
                            open_slabs   = k + 1;
                            r.addr       = region + 32'(k * PAGE);
                        end
                    end
                end
            end else if (addr != '0) begin
                diff = addr - region;
                slot = diff / PAGE;
                if (slot >= open_slabs) begin
                    r.status = ST_FOREIGN;
                end else begin
                    off = diff % PAGE;
                    sz  = slab_size[slot];
                    if (off >= (PAGE / sz) * sz) begin
                        // Slack at the end of the page where no whole block fits.
                        r.status = ST_FOREIGN;
                    end else begin
                        off = off - off % sz;
                        next_link[slot * LINKS + off / MIN_BLOCK] = head_off[slot];
                        head_off[slot] = off;
                    end
                end
            end
            pending_results.push_back(r);
            return r;
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_result(logic [ADDR_W-1:0] addr, status_t status);
            result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: addr=%h status=%0d",
                         $time, addr, status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (want.addr !== addr) begin
                $display("%0t: block_address expected %h actual %h", $time, want.addr, addr);
                mismatches++;
            end
            if (want.status !== status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [ADDR_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    slab_ledger  ledger = new();
    live_block_t live_blocks[$];
    bit [31:0]   freed_offsets[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned size_pool[12]  = '{4, 8, 12, 13, 24, 100, 1000, 1365, 2048, 3000, 4095, 4096};

    slab_block_allocator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Result side back-pressure.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on every request transfer and check every result transfer.
    always @(posedge aclk) begin
        result_t predicted;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predicted = ledger.note_request(s_tuser, s_tdata[12:0], s_tdata[44:13]);
                if (s_tuser == KIND_ALLOC && predicted.status == ST_OK) begin
                    live_blocks.push_back('{predicted.addr - ledger.region, s_tdata[12:0]});
                end
            end
            if (m_tvalid && m_tready) begin
                ledger.check_result(m_tdata[31:0], status_t'(m_tdata[33:32]));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request and returns at the falling edge after its transfer.
    task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, addr, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Lets every outstanding result arrive, then moves the region while idle.
    task automatic set_region(input logic [ADDR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (ledger.pending_results.size() != 0) @(negedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        ledger.region  = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One phase of random traffic, mostly allocations and frees of live blocks.
    task automatic run_phase(input logic [ADDR_W-1:0] region, input int unsigned idle_pct,
                             input int unsigned stall_pct);
        int unsigned       pick;
        int unsigned       idx;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        live_block_t       blk;
        set_region(region);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(99) < (live_blocks.size() < 48 ? 55 : 35)) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    size = $urandom_range(MIN_BLOCK - 1);
                end else if (pick < 15) begin
                    size = $urandom_range(PAGE, MIN_BLOCK);
                end else begin
                    size = size_pool[$urandom_range(11)];
                end
                send_request(KIND_ALLOC, size, $urandom);
            end else begin
                pick = $urandom_range(99);
                if (pick < 50 && live_blocks.size() != 0) begin
                    idx  = $urandom_range(live_blocks.size() - 1);
                    blk  = live_blocks[idx];
                    live_blocks.delete(idx);
                    addr = ledger.region + blk.offset;
                    if ($urandom_range(1)) begin
                        addr = addr + $urandom_range(blk.size - 1);
                    end
                    freed_offsets.push_back(blk.offset);
                    if (freed_offsets.size() > 32) begin
                        void'(freed_offsets.pop_front());
                    end
                end else if (pick < 60 && freed_offsets.size() != 0) begin
                    // Double free of a block already returned.
                    addr = ledger.region + freed_offsets[$urandom_range(freed_offsets.size() - 1)];
                end else if (pick < 70) begin
                    addr = '0;
                end else if (pick < 85) begin
                    addr = ledger.region + $urandom_range((SLABS + 1) * PAGE - 1);
                end else begin
                    addr = $urandom;
                end
                send_request(KIND_FREE, $urandom_range(PAGE), addr);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [ADDR_W-1:0] base;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: bad sizes, slack, wrap, unaligned, double and never-used frees.
        base = 32'h8000_0000;
        set_region(base);
        send_request(KIND_ALLOC, 0, $urandom);
        send_request(KIND_ALLOC, 3, $urandom);
        send_request(KIND_ALLOC, 4, $urandom);
        send_request(KIND_ALLOC, 4, $urandom);
        send_request(KIND_ALLOC, 4096, $urandom);
        send_request(KIND_ALLOC, 4096, $urandom);
        send_request(KIND_ALLOC, 4095, $urandom);
        send_request(KIND_FREE, 4096, '0);
        send_request(KIND_FREE, 0, base + 6);
        send_request(KIND_ALLOC, 4, 32'hFFFF_FFFF);
        send_request(KIND_FREE, 8191 & 4096, base + 3 * PAGE + 4095);
        send_request(KIND_FREE, 0, base + 4 * PAGE);
        send_request(KIND_FREE, 0, base - 1);
        send_request(KIND_FREE, 0, base);
        send_request(KIND_FREE, 0, base);
        send_request(KIND_ALLOC, 4, '0);
        send_request(KIND_ALLOC, 4, '0);
        send_request(KIND_FREE, 4095, base + 100);
        send_request(KIND_ALLOC, 4, '0);
        send_request(KIND_ALLOC, 4, '0);
        send_request(KIND_FREE, 0, 32'hFFFF_FFFF);
        send_request(KIND_ALLOC, 4096, 32'hFFFF_FFFF);
        send_request(KIND_FREE, 0, base + PAGE + 4095);
        send_request(KIND_ALLOC, 4096, '0);
        send_request(KIND_ALLOC, 13, '0);

        // Random phases under different regions and handshake pressure.
        run_phase(32'h0000_0000, 0, 0);
        run_phase(32'hFFFF_F000, 76, 0);
        run_phase({20'($urandom_range(32'hF_FFFF)), 12'h000}, 0, 76);
        run_phase(32'hFFFF_FFFF, 6, 6);

        while (ledger.pending_results.size() != 0) @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sba_pkg.sv
src/sba_ram.sv
src/sba_rem_unit.sv
src/slab_block_allocator_top.sv
src/sba_checker.sv
bench/slab_block_allocator_top_test.sv
